// ----- rtl/core/rhcb_pkg.sv -----
`timescale 1ns / 1ps

package rhcb_pkg;

	localparam int POS_BITS    = 32;
	localparam int OFFSET_W    = 32;
	localparam int HASH_W      = 64;
	localparam int DATA_W      = 8;
	localparam int MAX_WINDOW  = 1024;
	localparam int RING_AW     = $clog2(MAX_WINDOW);

	localparam int CHUNK_W     = 13;
	localparam int ESL_W       = 4;
	localparam int WIN_W       = 11;
	localparam int RF_W        = 64;

	localparam int HASH_MUL_W  = 30;
	localparam logic [HASH_MUL_W-1:0] HASH_MUL = 30'd892181971;

	localparam int MAX_PUSH    = 4;
	localparam int PUSH_CNT_W  = $clog2(MAX_PUSH + 1);
	localparam int PUSH_IDX_W  = $clog2(MAX_PUSH);
	localparam int QUEUE_DEPTH = 8;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int APB_DATA_W  = 64;
	localparam int APB_ADDR_W  = 5;
	localparam int REG_IDX_W   = 2;
	localparam int REG_IDX_LSB = 3;

	localparam logic [REG_IDX_W-1:0] REG_CHUNK_BYTES   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ELEMENT_LOG2  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WIN_LEN       = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DROP_MUL      = 2'd3;

	localparam logic [CHUNK_W-1:0] CHUNK_BYTES_RST   = 13'd64;
	localparam logic [ESL_W-1:0]   ELEMENT_LOG2_RST  = 4'd0;
	localparam logic [WIN_W-1:0]   WIN_LEN_RST       = 11'd1;
	localparam logic [RF_W-1:0]    DROP_MUL_RST      = 64'd1;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_bytes;
		logic [ESL_W-1:0]   element_size_log2;
		logic [WIN_W-1:0]   win_len;
		logic [RF_W-1:0]    drop_mul;
	} cfg_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic                last;
	} res_t;

	localparam int RES_BITS = $bits(res_t);

	typedef struct packed {
		logic [PUSH_CNT_W-1:0]     count;
		res_t [MAX_PUSH-1:0]       item;
	} push_t;

endpackage

// ----- rtl/core/rhcb_result_queue.sv -----
`timescale 1ns / 1ps

module rhcb_result_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rhcb_pkg::push_t                 push,
	output logic                            room,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rhcb_pkg::OFFSET_W-1:0]   out_offset,
	output logic                            out_last
);

	rhcb_pkg::res_t [rhcb_pkg::QUEUE_DEPTH-1:0] q_q;
	rhcb_pkg::res_t [rhcb_pkg::QUEUE_DEPTH-1:0] q_d;
	rhcb_pkg::res_t [rhcb_pkg::QUEUE_DEPTH-1:0] q_shift;
	logic [rhcb_pkg::QCNT_W-1:0] cnt_q;
	logic [rhcb_pkg::QCNT_W-1:0] cnt_d;
	logic [rhcb_pkg::QCNT_W-1:0] base;
	logic [rhcb_pkg::QCNT_W-1:0] k;
	logic pop;

	assign out_valid  = (cnt_q != '0);
	assign out_offset = q_q[0].offset;
	assign out_last   = q_q[0].last;
	assign pop        = out_valid & out_ready;
	assign room       = (cnt_q <= rhcb_pkg::QCNT_W'(rhcb_pkg::QUEUE_DEPTH - rhcb_pkg::MAX_PUSH));

	// head leaves at slot 0, everything behind it moves down one place
	assign q_shift = q_q >> rhcb_pkg::RES_BITS;
	assign base    = cnt_q - rhcb_pkg::QCNT_W'(pop);
	assign cnt_d   = base + rhcb_pkg::QCNT_W'(push.count);

	always_comb begin
		q_d = q_q;
		k   = '0;
		for (int j = 0; j < rhcb_pkg::QUEUE_DEPTH; j++) begin
			k = rhcb_pkg::QCNT_W'(j) - base;
			if (rhcb_pkg::QCNT_W'(j) < base) begin
				q_d[j] = pop ? q_shift[j] : q_q[j];
			end else if (k < rhcb_pkg::QCNT_W'(push.count)) begin
				q_d[j] = push.item[k[rhcb_pkg::PUSH_IDX_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		q_q <= q_d;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rhcb_pkg::QCNT_W'(rhcb_pkg::QUEUE_DEPTH))
		else $error("result queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != '0 |-> room)
		else $error("results pushed without room");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.count == '0) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("pop did not lower the count");
`endif

endmodule

// ----- rtl/core/rhcb_boundary_core.sv -----
`timescale 1ns / 1ps

module rhcb_boundary_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rhcb_pkg::cfg_t                 cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rhcb_pkg::DATA_W-1:0]    in_data,
	input  logic                           in_last,
	input  logic                           room,
	output rhcb_pkg::push_t                push
);

	localparam int PW = rhcb_pkg::POS_BITS;

	logic [rhcb_pkg::DATA_W-1:0] ring_mem [rhcb_pkg::MAX_WINDOW];

	logic                         valid_s1;
	logic                         last_s1;
	logic                         self_s1;
	logic [rhcb_pkg::DATA_W-1:0]  data_s1;
	logic [rhcb_pkg::DATA_W-1:0]  ring_s1;
	logic [PW-1:0]                pos_s1;

	logic [PW-1:0]                pos_q;
	logic [rhcb_pkg::HASH_W-1:0]  hash_q;
	logic [rhcb_pkg::HASH_W-1:0]  best_hash_q;
	logic [PW-1:0]                best_start_q;
	logic [PW-1:0]                rb_q;
	logic                         first_done_q;

	logic [rhcb_pkg::HASH_W-1:0]  hash_d;
	logic [rhcb_pkg::HASH_W-1:0]  best_hash_d;
	logic [PW-1:0]                best_start_d;
	logic [PW-1:0]                rb_d;
	logic                         first_done_d;

	logic                         adv;
	logic                         accept;
	logic [rhcb_pkg::WIN_W-1:0]   w_eff;
	logic [rhcb_pkg::CHUNK_W-1:0] c_eff;
	logic [rhcb_pkg::RING_AW-1:0] wr_addr;
	logic [rhcb_pkg::RING_AW-1:0] rd_addr;

	logic [61:0]                  lo_prod;
	logic [31:0]                  hi_prod;
	logic [rhcb_pkg::HASH_W-1:0]  h1;
	logic [rhcb_pkg::HASH_W-1:0]  rm_prod;
	logic [rhcb_pkg::DATA_W-1:0]  rm_byte;
	logic                         gt;

	logic [PW:0]                  p1;
	logic                         win_ok;
	logic [PW-1:0]                s_pos;
	logic [PW-1:0]                c_ext;
	logic [PW-1:0]                rb_c;
	logic [PW-1:0]                rb_2c;
	logic                         hit;
	logic [PW-1:0]                bstart_new;
	logic [rhcb_pkg::OFFSET_W-1:0] align;
	logic [rhcb_pkg::OFFSET_W-1:0] bnd_val;
	logic [rhcb_pkg::OFFSET_W-1:0] fin_val;
	logic [PW-1:0]                len;
	logic [PW-1:0]                diff;
	logic                         t1_ok;
	logic                         t2_ok;
	logic [rhcb_pkg::PUSH_CNT_W-1:0] n;

	assign adv      = valid_s1 & room;
	assign in_ready = ~valid_s1 | adv;
	assign accept   = in_valid & in_ready;

	always_comb begin
		if (cfg.win_len == '0) begin
			w_eff = rhcb_pkg::WIN_W'(1);
		end else if (cfg.win_len > rhcb_pkg::WIN_W'(rhcb_pkg::MAX_WINDOW)) begin
			w_eff = rhcb_pkg::WIN_W'(rhcb_pkg::MAX_WINDOW);
		end else begin
			w_eff = cfg.win_len;
		end
	end

	assign c_eff = (cfg.chunk_bytes == '0) ? rhcb_pkg::CHUNK_W'(1) : cfg.chunk_bytes;

	// read the byte leaving the window at accept time, w_eff - 1 places behind the write
	assign wr_addr = pos_q[rhcb_pkg::RING_AW-1:0];
	assign rd_addr = pos_q[rhcb_pkg::RING_AW-1:0] + rhcb_pkg::RING_AW'(1)
		- w_eff[rhcb_pkg::RING_AW-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[wr_addr] <= in_data;
			ring_s1           <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= in_data;
			last_s1 <= in_last;
			pos_s1  <= pos_q;
			self_s1 <= (w_eff == rhcb_pkg::WIN_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				pos_q    <= in_last ? '0 : pos_q + 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// hash * mul mod 2^64 split into a full low product and a truncated high one
	assign lo_prod = 62'(hash_q[31:0]) * 62'(rhcb_pkg::HASH_MUL);
	assign hi_prod = hash_q[63:32] * 32'(rhcb_pkg::HASH_MUL);
	assign h1      = {hi_prod, 32'b0} + 64'(lo_prod) + 64'(data_s1);
	assign rm_byte = self_s1 ? data_s1 : ring_s1;
	assign rm_prod = 64'(rm_byte) * cfg.drop_mul;
	assign gt      = (h1 > best_hash_q);

	assign p1     = {1'b0, pos_s1} + 1'b1;
	assign win_ok = (p1 >= (PW+1)'(w_eff));
	assign s_pos  = PW'(p1 - (PW+1)'(w_eff));
	assign c_ext  = PW'(c_eff);
	assign rb_c   = rb_q + c_ext;
	assign rb_2c  = rb_q + (c_ext << 1);
	assign hit    = win_ok && (s_pos == rb_c - 1'b1);

	assign align      = {rhcb_pkg::OFFSET_W{1'b1}} << cfg.element_size_log2;
	assign bstart_new = gt ? s_pos : best_start_q;
	assign bnd_val    = bstart_new & align;
	assign fin_val    = best_start_q & align;

	assign len   = p1[PW-1:0];
	assign diff  = len - rb_q;
	assign t1_ok = (len > rb_q) && (diff > c_ext);
	assign t2_ok = (len > rb_q) && (diff > (c_ext << 1));

	always_comb begin
		push         = '0;
		n            = '0;
		hash_d       = hash_q;
		best_hash_d  = best_hash_q;
		best_start_d = best_start_q;
		rb_d         = rb_q;
		first_done_d = first_done_q;
		if (adv) begin
			if (!last_s1) begin
				hash_d = h1;
				if (win_ok) begin
					hash_d = h1 - rm_prod;
					if (hit) begin
						if (!first_done_q && bnd_val != '0) begin
							push.item[n[rhcb_pkg::PUSH_IDX_W-1:0]].offset = '0;
							n = n + 1'b1;
						end
						push.item[n[rhcb_pkg::PUSH_IDX_W-1:0]].offset = bnd_val;
						n = n + 1'b1;
						rb_d         = rb_c;
						best_hash_d  = '0;
						best_start_d = rb_c;
						first_done_d = 1'b1;
					end else if (gt) begin
						best_hash_d  = h1;
						best_start_d = s_pos;
					end
				end
			end else begin
				if (!first_done_q && fin_val != '0) begin
					push.item[n[rhcb_pkg::PUSH_IDX_W-1:0]].offset = '0;
					n = n + 1'b1;
				end
				push.item[n[rhcb_pkg::PUSH_IDX_W-1:0]].offset = fin_val;
				n = n + 1'b1;
				if (t1_ok && n < rhcb_pkg::PUSH_CNT_W'(rhcb_pkg::MAX_PUSH - 1)) begin
					push.item[n[rhcb_pkg::PUSH_IDX_W-1:0]].offset = rb_c & align;
					n = n + 1'b1;
				end
				if (t2_ok && n < rhcb_pkg::PUSH_CNT_W'(rhcb_pkg::MAX_PUSH - 1)) begin
					push.item[n[rhcb_pkg::PUSH_IDX_W-1:0]].offset = rb_2c & align;
					n = n + 1'b1;
				end
				push.item[n[rhcb_pkg::PUSH_IDX_W-1:0]].offset = len;
				push.item[n[rhcb_pkg::PUSH_IDX_W-1:0]].last   = 1'b1;
				n = n + 1'b1;
				hash_d       = '0;
				best_hash_d  = '0;
				best_start_d = '0;
				rb_d         = '0;
				first_done_d = 1'b0;
			end
			push.count = n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q       <= '0;
			best_hash_q  <= '0;
			best_start_q <= '0;
			rb_q         <= '0;
			first_done_q <= 1'b0;
		end else begin
			hash_q       <= hash_d;
			best_hash_q  <= best_hash_d;
			best_start_q <= best_start_d;
			rb_q         <= rb_d;
			first_done_q <= first_done_d;
		end
	end

`ifndef SYNTHESIS
	a_mid_results: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !last_s1) |-> push.count <= rhcb_pkg::PUSH_CNT_W'(2))
		else $error("too many results for a mid-array item");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (rb_q == '0 && hash_q == '0 && !first_done_q))
		else $error("stream state not cleared after final item");

	a_fin_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |->
		push.item[rhcb_pkg::PUSH_IDX_W'(push.count - 1'b1)].last)
		else $error("final item list does not end in the length");
`endif

endmodule

// ----- rtl/core/rolling_hash_chunk_boundary_unit.sv -----
`timescale 1ns / 1ps
// channel  | direction | handshake              | payload
// s_axis   | in        | s_axis_tvalid/tready   | tdata[7:0] data_byte, tlast final_byte
// m_axis   | out       | m_axis_tvalid/tready   | tdata[31:0] offset, tlast final_offset
// apb      | in        | psel/penable, pready=1 | paddr 8*index, pwdata/prdata 64 bits
//
// One byte is accepted per cycle while the result queue has room; the hash update
// is one multiply-add-subtract pass. An offset reaches m_axis through the item
// register, then the result queue. A final byte yields up to four offsets, drained
// from the 8-deep queue one per cycle while m_axis_tready is high; the item register
// holds, and input stalls, while more than four offsets are waiting.
// Reset clears the registers to their defaults and the stream state; the byte ring is
// not cleared, as every entry whose value is used is written first within an array.

module rolling_hash_chunk_boundary_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [rhcb_pkg::DATA_W-1:0]        s_axis_tdata,   // [7:0] data_byte
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [rhcb_pkg::OFFSET_W-1:0]      m_axis_tdata,   // [31:0] offset
	output logic                               m_axis_tlast,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rhcb_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rhcb_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [rhcb_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);

	logic [rhcb_pkg::CHUNK_W-1:0] chunk_bytes_q;
	logic [rhcb_pkg::ESL_W-1:0]   element_log2_q;
	logic [rhcb_pkg::WIN_W-1:0]   win_len_q;
	logic [rhcb_pkg::RF_W-1:0]    drop_mul_q;
	logic [rhcb_pkg::REG_IDX_W-1:0] reg_idx;
	logic                         wr_en;
	rhcb_pkg::cfg_t               cfg;
	rhcb_pkg::push_t              push;
	logic                         room;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[rhcb_pkg::REG_IDX_LSB +: rhcb_pkg::REG_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q  <= rhcb_pkg::CHUNK_BYTES_RST;
			element_log2_q <= rhcb_pkg::ELEMENT_LOG2_RST;
			win_len_q      <= rhcb_pkg::WIN_LEN_RST;
			drop_mul_q     <= rhcb_pkg::DROP_MUL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				rhcb_pkg::REG_CHUNK_BYTES: begin
					chunk_bytes_q <= pwdata[rhcb_pkg::CHUNK_W-1:0];
				end
				rhcb_pkg::REG_ELEMENT_LOG2: begin
					element_log2_q <= pwdata[rhcb_pkg::ESL_W-1:0];
				end
				rhcb_pkg::REG_WIN_LEN: begin
					win_len_q <= pwdata[rhcb_pkg::WIN_W-1:0];
				end
				rhcb_pkg::REG_DROP_MUL: begin
					drop_mul_q <= pwdata[rhcb_pkg::RF_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rhcb_pkg::REG_CHUNK_BYTES:  prdata = rhcb_pkg::APB_DATA_W'(chunk_bytes_q);
			rhcb_pkg::REG_ELEMENT_LOG2: prdata = rhcb_pkg::APB_DATA_W'(element_log2_q);
			rhcb_pkg::REG_WIN_LEN:      prdata = rhcb_pkg::APB_DATA_W'(win_len_q);
			rhcb_pkg::REG_DROP_MUL:     prdata = drop_mul_q;
		endcase
	end

	assign cfg.chunk_bytes       = chunk_bytes_q;
	assign cfg.element_size_log2 = element_log2_q;
	assign cfg.win_len           = win_len_q;
	assign cfg.drop_mul          = drop_mul_q;

	rhcb_boundary_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.room     (room),
		.push     (push)
	);

	rhcb_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_offset (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule
